/* sv/rbs_pkg.sv */
// Shared types and constants for the ray versus box slab test.
// Used by every module of the block but rbs_div_pipe; no dependencies.
`default_nettype none
package rbs_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUOT_WIDTH      = 48;
   localparam int NUM_AXES        = 3;
   localparam int CSR_IDX_WIDTH   = 3;

   localparam logic signed [QUOT_WIDTH-1:0] QUOT_MAX = {1'b0, {(QUOT_WIDTH-1){1'b1}}};
   localparam logic signed [QUOT_WIDTH-1:0] QUOT_MIN = {1'b1, {(QUOT_WIDTH-1){1'b0}}};

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_MIN_X = 3'd0,
      CSR_MIN_Y = 3'd1,
      CSR_MIN_Z = 3'd2,
      CSR_MAX_X = 3'd3,
      CSR_MAX_Y = 3'd4,
      CSR_MAX_Z = 3'd5
   } csr_index_type;

   // Entry/exit distances of one axis and whether that axis can pass at all.
   typedef struct packed {
      logic signed [QUOT_WIDTH-1:0] t_near;
      logic signed [QUOT_WIDTH-1:0] t_far;
      logic                         pass;
   } axis_span_type;

endpackage
`default_nettype wire

/* sv/rbs_div_pipe.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a sideband tag alongside each beat; depends on nothing else.
`default_nettype none
module rbs_div_pipe #(
   parameter int NUM_WIDTH = 49,
   parameter int DEN_WIDTH = 32,
   parameter int TAG_WIDTH = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [NUM_WIDTH-1:0] in_num,
   input  wire logic [DEN_WIDTH-1:0] in_den,
   input  wire logic [TAG_WIDTH-1:0] in_tag,
   output logic                      out_valid,
   output logic      [NUM_WIDTH-1:0] out_quo,
   output logic      [TAG_WIDTH-1:0] out_tag
);

   logic                 valid_ff [NUM_WIDTH];
   logic [NUM_WIDTH-1:0] num_ff   [NUM_WIDTH];
   logic [NUM_WIDTH-1:0] quo_ff   [NUM_WIDTH];
   logic [DEN_WIDTH-1:0] rem_ff   [NUM_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff   [NUM_WIDTH];
   logic [TAG_WIDTH-1:0] tag_ff   [NUM_WIDTH];

   for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
      logic                 valid_src;
      logic [NUM_WIDTH-1:0] num_src;
      logic [NUM_WIDTH-1:0] quo_src;
      logic [DEN_WIDTH-1:0] rem_src;
      logic [DEN_WIDTH-1:0] den_src;
      logic [TAG_WIDTH-1:0] tag_src;
      logic [DEN_WIDTH:0]   trial;
      logic [DEN_WIDTH:0]   trial_sub;
      logic                 ge;

      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign num_src   = in_num;
         assign quo_src   = '0;
         assign rem_src   = '0;
         assign den_src   = in_den;
         assign tag_src   = in_tag;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign num_src   = num_ff[s-1];
         assign quo_src   = quo_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign tag_src   = tag_ff[s-1];
      end

      assign trial     = {rem_src, num_src[NUM_WIDTH-1]};
      assign ge        = trial >= {1'b0, den_src};
      assign trial_sub = trial - {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
         num_ff[s] <= num_src << 1;
         quo_ff[s] <= {quo_src[NUM_WIDTH-2:0], ge};
         rem_ff[s] <= ge ? trial_sub[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
         den_ff[s] <= den_src;
         tag_ff[s] <= tag_src;
      end
   end

   assign out_valid = valid_ff[NUM_WIDTH-1];
   assign out_quo   = quo_ff[NUM_WIDTH-1];
   assign out_tag   = tag_ff[NUM_WIDTH-1];

endmodule
`default_nettype wire

/* sv/rbs_axis_sat.sv */
// Per-axis saturation, sign restore and entry/exit ordering, two stages.
// Depends on rbs_pkg for the quotient width and the span struct.
`default_nettype none
module rbs_axis_sat
   import rbs_pkg::*;
#(
   parameter int NUM_WIDTH = 49
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [NUM_WIDTH-1:0] quo_lo,
   input  wire logic [NUM_WIDTH-1:0] quo_hi,
   input  wire logic                 neg_lo,
   input  wire logic                 neg_hi,
   input  wire logic                 par,
   input  wire logic                 axis_ok,
   output logic                      out_valid,
   output axis_span_type             out_span
);

   localparam int MW = (NUM_WIDTH > QUOT_WIDTH) ? NUM_WIDTH : QUOT_WIDTH;

   logic                         sat_valid_ff;
   logic signed [QUOT_WIDTH-1:0] t1_ff, t1_in;
   logic signed [QUOT_WIDTH-1:0] t2_ff, t2_in;
   logic                         par_ff;
   logic                         ok_ff;
   logic                         span_valid_ff;
   axis_span_type                span_ff, span_in;

   logic [MW-1:0] lim_lo, lim_hi, q_lo, q_hi, cl_lo, cl_hi;

   always_comb begin
      lim_lo = MW'(QUOT_MAX) + MW'(neg_lo);
      lim_hi = MW'(QUOT_MAX) + MW'(neg_hi);
      q_lo   = MW'(quo_lo);
      q_hi   = MW'(quo_hi);
      cl_lo  = (q_lo > lim_lo) ? lim_lo : q_lo;
      cl_hi  = (q_hi > lim_hi) ? lim_hi : q_hi;
      t1_in  = neg_lo ? -cl_lo[QUOT_WIDTH-1:0] : cl_lo[QUOT_WIDTH-1:0];
      t2_in  = neg_hi ? -cl_hi[QUOT_WIDTH-1:0] : cl_hi[QUOT_WIDTH-1:0];
   end

   always_comb begin
      span_in.pass = ok_ff;
      if (par_ff) begin
         // parallel axis puts no limit on the distances
         span_in.t_near = QUOT_MIN;
         span_in.t_far  = QUOT_MAX;
      end else if (t1_ff < t2_ff) begin
         span_in.t_near = t1_ff;
         span_in.t_far  = t2_ff;
      end else begin
         span_in.t_near = t2_ff;
         span_in.t_far  = t1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_valid_ff  <= 1'b0;
         span_valid_ff <= 1'b0;
      end else begin
         sat_valid_ff  <= in_valid;
         span_valid_ff <= sat_valid_ff;
      end
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      par_ff  <= par;
      ok_ff   <= axis_ok;
      span_ff <= span_in;
   end

   assign out_valid = span_valid_ff;
   assign out_span  = span_ff;

endmodule
`default_nettype wire

/* sv/rbs_combine.sv */
// Merges the three axis spans into near/far and the hit decision, two stages.
// Depends on rbs_pkg for the span struct.
`default_nettype none
module rbs_combine
   import rbs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid [NUM_AXES],
   input  wire axis_span_type in_span  [NUM_AXES],
   output logic               rsp_valid,
   output logic               rsp_hit
);

   logic                         nf_valid_ff;
   logic signed [QUOT_WIDTH-1:0] near_ff, near_in;
   logic signed [QUOT_WIDTH-1:0] far_ff, far_in;
   logic                         pass_ff, pass_in;
   logic                         out_valid_ff;
   logic                         hit_ff, hit_in;
   logic                         valid_all;

   always_comb begin
      valid_all = 1'b1;
      near_in   = QUOT_MIN;
      far_in    = QUOT_MAX;
      pass_in   = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
         valid_all = valid_all & in_valid[a];
         pass_in   = pass_in & in_span[a].pass;
         if (in_span[a].t_near > near_in) begin
            near_in = in_span[a].t_near;
         end
         if (in_span[a].t_far < far_in) begin
            far_in = in_span[a].t_far;
         end
      end
   end

   assign hit_in = nf_valid_ff && pass_ff && !far_ff[QUOT_WIDTH-1] && !(near_ff > far_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         nf_valid_ff  <= valid_all;
         out_valid_ff <= nf_valid_ff;
         hit_ff       <= hit_in;
      end
      near_ff <= near_in;
      far_ff  <= far_in;
      pass_ff <= pass_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_hit   = hit_ff;

endmodule
`default_nettype wire

/* sv/ray_box_slab_test.sv */
// Ray versus axis-aligned box slab test, one ray per cycle, fully pipelined.
// A request is registered, then passes the bit-per-stage dividers, the per-axis
// saturation stages and the combine stages to rsp_valid. Throughput: one ray per cycle;
// busy stays low and the result strobe cannot be held off.
// Reset (synchronous, active high) clears box registers and all valid bits.
// Depends on rbs_pkg, rbs_div_pipe, rbs_axis_sat and rbs_combine.
`default_nettype none
module ray_box_slab_test
   import rbs_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_start,
   output logic                               req_busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_origin_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_z,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_IDX_WIDTH-1:0]      csr_index,
   input  wire logic [COORD_WIDTH-1:0]        csr_data
);

   localparam int NUM_WIDTH = COORD_WIDTH + 1 + FRAC_BITS;
   localparam int LATENCY   = NUM_WIDTH + 5;

   logic signed [COORD_WIDTH-1:0] min_ff [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] max_ff [NUM_AXES];

   logic signed [COORD_WIDTH-1:0] org [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] dir [NUM_AXES];

   logic                 fr_valid_ff;
   logic [NUM_WIDTH-1:0] num_lo_ff [NUM_AXES];
   logic [NUM_WIDTH-1:0] num_hi_ff [NUM_AXES];
   logic [NUM_WIDTH-1:0] num_lo_in [NUM_AXES];
   logic [NUM_WIDTH-1:0] num_hi_in [NUM_AXES];
   logic [COORD_WIDTH-1:0] den_ff [NUM_AXES];
   logic [COORD_WIDTH-1:0] den_in [NUM_AXES];
   logic neg_lo_ff [NUM_AXES], neg_lo_in [NUM_AXES];
   logic neg_hi_ff [NUM_AXES], neg_hi_in [NUM_AXES];
   logic par_ff    [NUM_AXES], par_in    [NUM_AXES];
   logic ok_ff     [NUM_AXES], ok_in     [NUM_AXES];

   logic          span_valid [NUM_AXES];
   axis_span_type span       [NUM_AXES];

   logic accept;

   assign req_busy  = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = req_start && !req_busy;

   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   // box registers; an index past the list drops the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            min_ff[a] <= '0;
            max_ff[a] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_X: min_ff[0] <= csr_data;
            CSR_MIN_Y: min_ff[1] <= csr_data;
            CSR_MIN_Z: min_ff[2] <= csr_data;
            CSR_MAX_X: max_ff[0] <= csr_data;
            CSR_MAX_Y: max_ff[1] <= csr_data;
            CSR_MAX_Z: max_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [COORD_WIDTH:0] d_lo, d_hi;
      logic        [COORD_WIDTH:0] m_lo, m_hi;
      for (int a = 0; a < NUM_AXES; a++) begin
         d_lo = {min_ff[a][COORD_WIDTH-1], min_ff[a]} - {org[a][COORD_WIDTH-1], org[a]};
         d_hi = {max_ff[a][COORD_WIDTH-1], max_ff[a]} - {org[a][COORD_WIDTH-1], org[a]};
         m_lo = d_lo[COORD_WIDTH] ? -d_lo : d_lo;
         m_hi = d_hi[COORD_WIDTH] ? -d_hi : d_hi;
         num_lo_in[a] = NUM_WIDTH'(m_lo) << FRAC_BITS;
         num_hi_in[a] = NUM_WIDTH'(m_hi) << FRAC_BITS;
         neg_lo_in[a] = d_lo[COORD_WIDTH] ^ dir[a][COORD_WIDTH-1];
         neg_hi_in[a] = d_hi[COORD_WIDTH] ^ dir[a][COORD_WIDTH-1];
         den_in[a]    = dir[a][COORD_WIDTH-1] ? -dir[a] : dir[a];
         par_in[a]    = (dir[a] == '0);
         ok_in[a]     = !par_in[a] || (org[a] >= min_ff[a] && org[a] <= max_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= accept;
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         num_lo_ff[a] <= num_lo_in[a];
         num_hi_ff[a] <= num_hi_in[a];
         den_ff[a]    <= den_in[a];
         neg_lo_ff[a] <= neg_lo_in[a];
         neg_hi_ff[a] <= neg_hi_in[a];
         par_ff[a]    <= par_in[a];
         ok_ff[a]     <= ok_in[a];
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic                 lo_valid, hi_valid;
      logic [NUM_WIDTH-1:0] quo_lo, quo_hi;
      logic [2:0]           tag_lo;
      logic [0:0]           tag_hi;

      rbs_div_pipe #(
         .NUM_WIDTH (NUM_WIDTH),
         .DEN_WIDTH (COORD_WIDTH),
         .TAG_WIDTH (3)
      ) u_div_lo (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (fr_valid_ff),
         .in_num    (num_lo_ff[a]),
         .in_den    (den_ff[a]),
         .in_tag    ({par_ff[a], ok_ff[a], neg_lo_ff[a]}),
         .out_valid (lo_valid),
         .out_quo   (quo_lo),
         .out_tag   (tag_lo)
      );

      rbs_div_pipe #(
         .NUM_WIDTH (NUM_WIDTH),
         .DEN_WIDTH (COORD_WIDTH),
         .TAG_WIDTH (1)
      ) u_div_hi (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (fr_valid_ff),
         .in_num    (num_hi_ff[a]),
         .in_den    (den_ff[a]),
         .in_tag    (neg_hi_ff[a]),
         .out_valid (hi_valid),
         .out_quo   (quo_hi),
         .out_tag   (tag_hi)
      );

      rbs_axis_sat #(
         .NUM_WIDTH (NUM_WIDTH)
      ) u_sat (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lo_valid && hi_valid),
         .quo_lo    (quo_lo),
         .quo_hi    (quo_hi),
         .neg_lo    (tag_lo[0]),
         .neg_hi    (tag_hi[0]),
         .par       (tag_lo[2]),
         .axis_ok   (tag_lo[1]),
         .out_valid (span_valid[a]),
         .out_span  (span[a])
      );
   end

   rbs_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (span_valid),
      .in_span   (span),
      .rsp_valid (rsp_valid),
      .rsp_hit   (rsp_hit)
   );

`ifndef ASSERT_OFF
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result beat without a matching request");

   a_hit_needs_valid: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_hit)
      else $error("hit raised outside a result beat");

   a_axes_aligned: assert property (@(posedge clock) disable iff (reset)
      span_valid[0] |-> (span_valid[1] && span_valid[2]))
      else $error("axis pipelines out of step");
`endif

endmodule
`default_nettype wire

/* tb/ray_box_slab_test_tb.sv */
// Self-checking testbench for ray_box_slab_test: drives rays against a
// configured box, predicts each hit bit in the bench and compares results.
// Depends on rbs_pkg and ray_box_slab_test.
`timescale 1ns / 1ps
module ray_box_slab_test_tb;
   import rbs_pkg::*;

   localparam int CW      = 32;
   localparam int FB      = 16;
   localparam int LATENCY = CW + FB + 6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic signed [CW-1:0] ONE   = 32'sh0001_0000;
   localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [CW-1:0] C_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic signed [CW-1:0] ox, oy, oz;
      logic signed [CW-1:0] dx, dy, dz;
   } ray_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_start = 1'b0;
   logic req_busy;
   logic signed [CW-1:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [CW-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid, rsp_hit;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = CSR_MIN_X;
   logic [CW-1:0] csr_data = '0;

   logic signed [CW-1:0] box_bound [6];
   bit   hit_queue [$];
   int   errors = 0;
   int   sender_idle_pct = 0;

   ray_box_slab_test i_dut (
      .clock, .reset, .req_start, .req_busy,
      .req_origin_x, .req_origin_y, .req_origin_z,
      .req_dir_x, .req_dir_y, .req_dir_z,
      .rsp_valid, .rsp_hit,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Slab distance (bound - origin) / dir in Q32.16, truncated, saturated.
   function automatic logic signed [63:0] slab_dist(logic signed [CW-1:0] bound,
                                                    logic signed [CW-1:0] org,
                                                    logic signed [CW-1:0] dir);
      logic signed [63:0] num, q;
      num = (64'(bound) - 64'(org)) <<< FB;
      q = num / 64'(dir);
      if (q > 64'(QUOT_MAX)) q = 64'(QUOT_MAX);
      if (q < 64'(QUOT_MIN)) q = 64'(QUOT_MIN);
      return q;
   endfunction

   function automatic bit predict_hit(ray_type r);
      logic signed [CW-1:0] org [3];
      logic signed [CW-1:0] dir [3];
      logic signed [63:0] t_near, t_far, t1, t2;
      bit ok;
      org[0] = r.ox; org[1] = r.oy; org[2] = r.oz;
      dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
      t_near = 64'(QUOT_MIN);
      t_far  = 64'(QUOT_MAX);
      ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (dir[a] == 0) begin
            if (org[a] < box_bound[a] || org[a] > box_bound[a+3]) ok = 1'b0;
         end else begin
            t1 = slab_dist(box_bound[a], org[a], dir[a]);
            t2 = slab_dist(box_bound[a+3], org[a], dir[a]);
            if (t1 > t2) begin
               t_near = (t2 > t_near) ? t2 : t_near;
               t_far  = (t1 < t_far) ? t1 : t_far;
            end else begin
               t_near = (t1 > t_near) ? t1 : t_near;
               t_far  = (t2 < t_far) ? t2 : t_far;
            end
         end
      end
      if (t_far < 0 || t_near > t_far) ok = 1'b0;
      return ok;
   endfunction

   // Queue on each accepted ray, compare on each result strobe.
   always @(posedge clock) begin
      ray_type r;
      bit want;
      if (!reset) begin
         if (req_start && !req_busy) begin
            r = '{req_origin_x, req_origin_y, req_origin_z, req_dir_x, req_dir_y, req_dir_z};
            hit_queue.push_back(predict_hit(r));
         end
         if (rsp_valid) begin
            if (hit_queue.size() == 0) begin
               $display("%0t: unexpected result beat, hit=%0b", $time, rsp_hit);
               errors++;
            end else begin
               want = hit_queue.pop_front();
               if (rsp_hit !== want) begin
                  $display("%0t: hit mismatch, expected %0b actual %0b", $time, want, rsp_hit);
                  errors++;
               end
            end
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_WIDTH-1:0] idx, logic [CW-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      if (idx < 6) box_bound[idx] = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_box(logic signed [CW-1:0] x0, y0, z0, x1, y1, z1);
      write_csr(CSR_MIN_X, x0);
      write_csr(CSR_MIN_Y, y0);
      write_csr(CSR_MIN_Z, z0);
      write_csr(CSR_MAX_X, x1);
      write_csr(CSR_MAX_Y, y1);
      write_csr(CSR_MAX_Z, z1);
   endtask

   // Wait out every expected result, then the pipeline depth.
   task automatic drain();
      while (hit_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   task automatic send_ray(ray_type r);
      @(negedge clock);
      req_origin_x = r.ox; req_origin_y = r.oy; req_origin_z = r.oz;
      req_dir_x = r.dx; req_dir_y = r.dy; req_dir_z = r.dz;
      req_start = 1'b1;
      while (req_busy) @(negedge clock);
      @(posedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_start = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
   endtask

   task automatic end_beats();
      @(negedge clock);
      req_start = 1'b0;
   endtask

   function automatic logic signed [CW-1:0] rand_coord(bit allow_zero);
      case ($urandom_range(allow_zero ? 5 : 4))
         0, 1: return $urandom;
         2: return $signed($urandom_range(2 * (1 << 20))) - (1 << 20);
         3: case ($urandom_range(4))
               0: return C_MIN;
               1: return C_MAX;
               2: return 1;
               3: return -1;
               default: return ONE;
            endcase
         4: return $signed($urandom_range(16)) - 8;
         default: return 0;
      endcase
   endfunction

   function automatic logic signed [CW-1:0] aim(logic signed [CW-1:0] target,
                                                logic signed [CW-1:0] org);
      logic signed [63:0] d;
      d = 64'(target) - 64'(org);
      while (d > 64'(C_MAX) || d < 64'(C_MIN)) d = d >>> 1;
      return d[CW-1:0];
   endfunction

   // Mostly rays aimed at a point near the box's min corner; the rest are noise.
   function automatic ray_type rand_ray();
      ray_type r;
      logic signed [CW-1:0] p [3];
      if ($urandom_range(99) < 60) begin
         for (int a = 0; a < 3; a++)
            p[a] = (box_bound[a] <= box_bound[a+3])
                   ? box_bound[a] + $signed($urandom_range(0, 1 << 10)) : box_bound[a];
         r.ox = rand_coord(0); r.oy = rand_coord(0); r.oz = rand_coord(0);
         r.dx = aim(p[0], r.ox); r.dy = aim(p[1], r.oy); r.dz = aim(p[2], r.oz);
         if ($urandom_range(9) == 0) r.dy = 0;
      end else begin
         r = '{rand_coord(0), rand_coord(0), rand_coord(0),
               rand_coord(1), rand_coord(1), rand_coord(1)};
      end
      return r;
   endfunction

   task automatic random_box();
      logic signed [CW-1:0] lo [3];
      for (int a = 0; a < 3; a++)
         lo[a] = $signed($urandom_range(1 << 23)) - (1 << 22);
      set_box(lo[0], lo[1], lo[2],
              lo[0] + $signed($urandom_range(1 << 22)),
              lo[1] + $signed($urandom_range(1 << 22)),
              lo[2] + $signed($urandom_range(1 << 22)));
   endtask

   task automatic test_directed();
      set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
      send_ray('{-5 * ONE, 0, 0, ONE, 0, 0});            // straight through
      send_ray('{-5 * ONE, 0, 0, -ONE, 0, 0});           // pointing away
      send_ray('{0, 0, 0, 0, 0, 0});                     // all parallel, inside
      send_ray('{2 * ONE, 0, 0, 0, 0, 0});               // all parallel, outside
      send_ray('{ONE, ONE, ONE, 0, 0, 0});               // parallel on the faces
      send_ray('{ONE + 1, 0, 0, 0, ONE, 0});             // parallel just outside
      send_ray('{-3 * ONE, 2 * ONE, 0, ONE, 0, 0});      // parallel axis misses
      send_ray('{-3 * ONE, -3 * ONE, 0, ONE, ONE, 0});   // diagonal
      send_ray('{-3 * ONE, -9 * ONE, 0, ONE, ONE, 0});   // diagonal miss
      send_ray('{C_MIN, 0, 0, 1, 0, 0});                 // saturated distances
      send_ray('{C_MAX, 0, 0, -1, 0, 0});
      send_ray('{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX});
      send_ray('{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN});
      send_ray('{0, 0, 0, C_MIN, 1, -1});                // origin inside
      send_ray('{ONE * 2, 0, 0, -1, 0, 0});
      end_beats();
      drain();
      set_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
      send_ray('{C_MIN, C_MAX, 0, 0, 0, 0});
      send_ray('{C_MAX, C_MIN, 0, C_MIN, C_MAX, 1});
      send_ray('{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN});
      end_beats();
      drain();
      set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);          // inverted box
      send_ray('{0, 0, 0, 0, 0, 0});
      send_ray('{-5 * ONE, -5 * ONE, -5 * ONE, ONE, ONE, ONE});
      send_ray('{5 * ONE, 0, 0, -ONE, ONE, ONE});
      end_beats();
      drain();
      // Spare indexes must not disturb the box.
      write_csr(CSR_SPARE_LO, C_MAX);
      write_csr(CSR_SPARE_HI, C_MIN);
      set_box(0, 0, 0, 0, 0, 0);
      send_ray('{0, 0, 0, 0, 0, 0});
      send_ray('{-ONE, 0, 0, ONE, 0, 0});
      end_beats();
      drain();
   endtask

   task automatic test_random_phase(int idle_pct, int count);
      sender_idle_pct = idle_pct;
      random_box();
      for (int n = 0; n < count; n++) begin
         send_ray(rand_ray());
         // With 48 percent idle, hold off once until every result is back.
         if (n == count / 2 && idle_pct == 48) begin
            end_beats();
            while (hit_queue.size() != 0) @(negedge clock);
         end
      end
      end_beats();
      drain();
   endtask

   task automatic test_extreme_box();
      sender_idle_pct = 21;
      set_box(C_MIN, -ONE, 0, C_MIN + 1, C_MAX, C_MAX);
      for (int n = 0; n < 60; n++) send_ray(rand_ray());
      end_beats();
      drain();
   endtask

   initial begin
      for (int i = 0; i < 6; i++) box_bound[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_phase(0, 220);
      test_random_phase(48, 220);
      test_random_phase(21, 220);
      test_extreme_box();
      test_random_phase(0, 180);
      while (hit_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* ray_box_slab_test.f */
sv/rbs_pkg.sv
sv/rbs_div_pipe.sv
sv/rbs_axis_sat.sv
sv/rbs_combine.sv
sv/ray_box_slab_test.sv
tb/ray_box_slab_test_tb.sv
